@@ design/chroma_vertical_upsampler_macros.svh @@
// Assertion helpers used by the checker of this block.
`ifndef CHROMA_VERTICAL_UPSAMPLER_MACROS_SVH
`define CHROMA_VERTICAL_UPSAMPLER_MACROS_SVH

// Checked only outside reset.
`define CVU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define CVU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/cvu_pkg.sv @@
package cvu_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int HIST_W       = 24;
  localparam int LINE_WIDTH_W = 11;
  localparam int LINE_COUNT_W = 12;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 10;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd960;
  localparam logic [LINE_COUNT_W-1:0] LINE_COUNT_RST = 12'd540;

  // register index = paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Classified item handed from front to back.
  // hist: bits 7:0 line m-1, 15:8 line m-2, 23:16 line m-3.
  // r_first: distance (m - k) of the first line to emit.
  typedef struct packed {
    sample_t           x;
    logic [HIST_W-1:0] hist;
    logic              has_res;
    logic              last_line;
    logic [1:0]        r_first;
  } cvu_cls_t;

endpackage

@@ design/cvu_ram.sv @@
module cvu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/cvu_queue.sv @@
module cvu_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/cvu_front.sv @@
module cvu_front import cvu_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_LINES   = 2048,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int LW = $clog2(MAX_LINES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [LINE_WIDTH_W-1:0] line_width_i,
  input  logic [LINE_COUNT_W-1:0] line_count_i,
  input  logic                    in_valid_i,
  input  sample_t                 chroma_in_i,
  output logic                    in_stall_o,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output cvu_cls_t                q_cls_o,
  output logic [CW-1:0]           q_col_o,
  output logic [LW-1:0]           q_line_o
);

  logic [CW:0]       w_eff;
  logic [LW:0]       h_eff;
  logic [CW-1:0]     col_q, col_d;
  logic [LW-1:0]     line_q, line_d;
  logic [LW-1:0]     m_eff;
  logic              last_line, eol, accept;

  logic              s1_valid_q;
  sample_t           s1_x_q;
  logic [CW-1:0]     s1_col_q;
  logic [LW-1:0]     s1_m_q;
  logic              s1_last_q;
  logic              fwd_q;
  logic [HIST_W-1:0] fwd_data_q;
  logic [HIST_W-1:0] rd_data, hist, wr_data;
  logic              m_ge2;

  // effective frame size: zero acts as one, oversize saturates
  always_comb begin
    if (line_width_i == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(line_width_i) > 32'(MAX_COLUMNS)) begin
      w_eff = (CW+1)'(MAX_COLUMNS);
    end else begin
      w_eff = (CW+1)'(line_width_i);
    end
    if (line_count_i == '0) begin
      h_eff = (LW+1)'(1);
    end else if (32'(line_count_i) > 32'(MAX_LINES)) begin
      h_eff = (LW+1)'(MAX_LINES);
    end else begin
      h_eff = (LW+1)'(line_count_i);
    end
  end

  assign m_eff     = ({1'b0, line_q} >= h_eff) ? LW'(h_eff - (LW+1)'(1)) : line_q;
  assign last_line = ({1'b0, m_eff} == h_eff - (LW+1)'(1));
  assign eol       = (({1'b0, col_q} + (CW+1)'(1)) >= w_eff);

  assign q_push_o   = s1_valid_q && !q_full_i;
  assign in_stall_o = s1_valid_q && !q_push_o;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d  = col_q;
    line_d = line_q;
    if (accept) begin
      if (eol) begin
        col_d  = '0;
        line_d = last_line ? '0 : m_eff + LW'(1);
      end else begin
        col_d  = col_q + CW'(1);
        line_d = m_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      line_q     <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      col_q  <= col_d;
      line_q <= line_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
        // same column written back this edge: the RAM read misses it
        fwd_q      <= q_push_o && (s1_col_q == col_q);
      end else if (q_push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= chroma_in_i;
      s1_col_q   <= col_q;
      s1_m_q     <= m_eff;
      s1_last_q  <= last_line;
      fwd_data_q <= wr_data;
    end
  end

  cvu_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (q_push_o),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .rd_data_o (rd_data)
  );

  assign hist    = fwd_q ? fwd_data_q : rd_data;
  assign wr_data = {hist[HIST_W-SAMPLE_W-1:0], s1_x_q};
  assign m_ge2   = (s1_m_q > LW'(1));

  always_comb begin
    q_cls_o.x         = s1_x_q;
    q_cls_o.hist      = hist;
    q_cls_o.last_line = s1_last_q;
    q_cls_o.has_res   = s1_last_q || m_ge2;
    if (s1_last_q && !m_ge2) begin
      q_cls_o.r_first = s1_m_q[0] ? 2'd1 : 2'd0;
    end else begin
      q_cls_o.r_first = 2'd2;
    end
  end

  assign q_col_o  = s1_col_q;
  assign q_line_o = s1_m_q;

endmodule

@@ design/cvu_back.sv @@
module cvu_back import cvu_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_LINES   = 2048,
  localparam int CW = $clog2(MAX_COLUMNS),
  localparam int LW = $clog2(MAX_LINES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cvu_cls_t         q_cls_i,
  input  logic [CW-1:0]    q_col_i,
  input  logic [LW-1:0]    q_line_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sample_t          chroma_out_o,
  output logic [ROW_W-1:0] out_row_o,
  output logic [COL_W-1:0] out_col_o,
  output logic             run_last_o
);

  // 0: incoming sample, 1..3: stored lines m-1..m-3
  function automatic sample_t pick(input logic [1:0] code, input sample_t x,
                                   input logic [HIST_W-1:0] h);
    sample_t v;
    case (code)
      2'd0:    v = x;
      2'd1:    v = h[7:0];
      2'd2:    v = h[15:8];
      default: v = h[23:16];
    endcase
    return v;
  endfunction

  logic          first_q;
  logic [1:0]    r_q, cur_r, stop_r, code_a, code_c;
  logic          ph_q;
  logic          final_res, load_ok, emit;
  logic [LW-1:0] k;
  sample_t       a, b, c, d, interp, value;
  logic [8:0]    sum_bc, sum_ad;
  logic [12:0]   t, diff;

  logic             out_valid_q;
  sample_t          chroma_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             last_q;

  assign cur_r     = first_q ? q_cls_i.r_first : r_q;
  assign stop_r    = q_cls_i.last_line ? 2'd0 : 2'd2;
  assign final_res = ph_q && (cur_r == stop_r);
  assign load_ok   = !out_valid_q || !out_stall_i;
  assign emit      = q_valid_i && q_cls_i.has_res && load_ok;
  assign q_pop_o   = q_valid_i && (!q_cls_i.has_res || (emit && final_res));

  // k = m - r; the top edge clamps line k-1 to line 0 (then m == r)
  assign k      = q_line_i - LW'(cur_r);
  assign code_a = (k == '0) ? cur_r : cur_r + 2'd1;
  assign code_c = (cur_r == 2'd0) ? 2'd0 : cur_r - 2'd1;

  assign a = pick(code_a, q_cls_i.x, q_cls_i.hist);
  assign b = pick(cur_r, q_cls_i.x, q_cls_i.hist);
  assign c = pick(code_c, q_cls_i.x, q_cls_i.hist);
  assign d = q_cls_i.x;

  // (9*(b+c) - (a+d) + 8) >> 4, clipped to 0..255
  assign sum_bc = {1'b0, b} + {1'b0, c};
  assign sum_ad = {1'b0, a} + {1'b0, d};
  assign t      = {1'b0, sum_bc, 3'b000} + {4'b0, sum_bc} + 13'd8;
  assign diff   = t - {4'b0, sum_ad};

  always_comb begin
    if ({4'b0, sum_ad} > t) begin
      interp = '0;
    end else if (diff[12]) begin
      interp = 8'hFF;
    end else begin
      interp = diff[11:4];
    end
    value = ph_q ? interp : b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= 1'b1;
      r_q         <= 2'd0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        if (final_res) begin
          first_q <= 1'b1;
          ph_q    <= 1'b0;
        end else if (ph_q) begin
          first_q <= 1'b0;
          r_q     <= cur_r - 2'd1;
          ph_q    <= 1'b0;
        end else begin
          first_q <= 1'b0;
          r_q     <= cur_r;
          ph_q    <= 1'b1;
        end
      end
      if (load_ok) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      chroma_q <= value;
      row_q    <= ROW_W'({k, ph_q});
      col_q    <= COL_W'(q_col_i);
      last_q   <= final_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chroma_out_o = chroma_q;
  assign out_row_o    = row_q;
  assign out_col_o    = col_q;
  assign run_last_o   = last_q;

endmodule

@@ design/chroma_vertical_upsampler.sv @@
// Chroma vertical upsampler: takes a vertically subsampled chroma plane one
// sample per item in raster order and doubles its height. Line k gives row
// 2k (copy) and row 2k+1 = (9*(L[k]+L[k+1]) - (L[k-1]+L[k+2]) + 8) >> 4,
// clipped to 0..255, line indices clamped to the plane. A sample of line m
// releases rows 2(m-2) and 2(m-2)+1 of its column; on the last line it also
// flushes the rows of lines m-1 and m, so an item yields 0, 2, 4 or 6
// results, each tagged with row, column and run_last on the final one.
// Rate: the output side moves one result per cycle while out_stall_i is
// low; the input side takes one item a cycle while the 4-entry queue has
// room. From accept to first result an item passes the line store read,
// the queue and the output register. The line store is a single RAM of
// MAX_COLUMNS x 24 bits with one read and one write port; a write-to-read
// bypass covers back-to-back items on the same column. The store needs no
// clearing after reset. Registers (APB, 32-bit data): 0x0 line_width (11
// bits, reset 960), 0x4 line_count (12 bits, reset 540); zero acts as
// one, values above the parameters saturate. Write them only while the
// block is idle.
module chroma_vertical_upsampler import cvu_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_LINES   = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sample_t               chroma_in_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sample_t               chroma_out_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_col_o,
  output logic                  run_last_o
);

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int LW = $clog2(MAX_LINES);
  localparam int QW = $bits(cvu_cls_t) + CW + LW;

  logic [LINE_WIDTH_W-1:0] line_width_q;
  logic [LINE_COUNT_W-1:0] line_count_q;
  logic                    cfg_wr;

  // APB: zero wait states, register index in paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      line_count_q <= LINE_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LINE_WIDTH: line_width_q <= pwdata[LINE_WIDTH_W-1:0];
        REG_LINE_COUNT: line_count_q <= pwdata[LINE_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LINE_WIDTH: prdata = APB_DATA_W'(line_width_q);
      REG_LINE_COUNT: prdata = APB_DATA_W'(line_count_q);
      default:        prdata = '0;
    endcase
  end

  // front -> queue -> back
  logic           push, full, pop, q_valid;
  cvu_cls_t       f_cls, b_cls;
  logic [CW-1:0]  f_col, b_col;
  logic [LW-1:0]  f_line, b_line;
  logic [QW-1:0]  q_wdata, q_rdata;

  cvu_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .line_width_i (line_width_q),
    .line_count_i (line_count_q),
    .in_valid_i   (in_valid_i),
    .chroma_in_i  (chroma_in_i),
    .in_stall_o   (in_stall_o),
    .q_full_i     (full),
    .q_push_o     (push),
    .q_cls_o      (f_cls),
    .q_col_o      (f_col),
    .q_line_o     (f_line)
  );

  assign q_wdata = {f_cls, f_col, f_line};

  cvu_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {b_cls, b_col, b_line} = q_rdata;

  cvu_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_LINES   (MAX_LINES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cls_i      (b_cls),
    .q_col_i      (b_col),
    .q_line_i     (b_line),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .chroma_out_o (chroma_out_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .run_last_o   (run_last_o)
  );

endmodule

@@ design/cvu_checker.sv @@
`include "chroma_vertical_upsampler_macros.svh"

module cvu_checker import cvu_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input sample_t          chroma_out_o,
  input logic [ROW_W-1:0] out_row_o,
  input logic [COL_W-1:0] out_col_o,
  input logic             run_last_o
);

  `CVU_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

  `CVU_ASSERT(a_valid_held, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  `CVU_ASSERT(a_payload_held, out_valid_o && out_stall_i |=> $stable(chroma_out_o) && $stable(out_row_o) && $stable(out_col_o) && $stable(run_last_o), "stalled result changed")

  `CVU_ASSERT(a_last_on_odd, out_valid_o && run_last_o |-> out_row_o[0], "run_last on an even row")

  `CVU_ASSERT(a_pair_follows, out_valid_o && !out_stall_i && !out_row_o[0] |=> out_valid_o && out_row_o[0] && (out_row_o[ROW_W-1:1] == $past(out_row_o[ROW_W-1:1])) && (out_col_o == $past(out_col_o)), "odd row does not follow its even row")

endmodule

bind chroma_vertical_upsampler cvu_checker u_cvu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .chroma_out_o (chroma_out_o),
  .out_row_o    (out_row_o),
  .out_col_o    (out_col_o),
  .run_last_o   (run_last_o)
);
